@@ hw/rtl/bts_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bts_pkg
// shared types, constants and the srgb decode table of the texture sampler
// ---------------------------------------------------------------------------
package bts_pkg;

    localparam int unsigned MAX_DIM_DEF     = 64;
    localparam int unsigned TEXEL_DEPTH_DEF = 4096;

    localparam int unsigned FRAC_W     = 16;   // sub-texel offset bits
    localparam int unsigned CHAN_W     = 16;   // filtered channel width
    localparam int unsigned ADDR_W     = 12;   // request texel address width
    localparam int unsigned TEXEL_W    = 32;   // rgba8 texel
    localparam int unsigned COORD_W    = 24;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned SIZE_W     = 7;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEX_WIDTH       = 3'd0,
        CFG_TEX_HEIGHT      = 3'd1,
        CFG_SRGB_DECODE     = 3'd2,
        CFG_TEXTURE_PRESENT = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        t_cmd                       command;
        logic [ADDR_W-1:0]          texel_address;
        logic [TEXEL_W-1:0]         texel_data;
        logic signed [COORD_W-1:0]  coord_u;
        logic signed [COORD_W-1:0]  coord_v;
    } t_req;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } t_rsp;

    typedef logic [255:0][CHAN_W-1:0] t_srgb_lut;

    // truncating q30 fifth power
    function automatic logic [63:0] pow5_q30(input logic [63:0] y);
        logic [63:0] p;
        int          k;
        p = y;
        for (k = 0; k < 4; k++) begin
            p = (p * y) >> 30;
        end
        return p;
    endfunction

    // srgb byte to 16-bit linear, exact integer form of the transfer curve
    function automatic logic [CHAN_W-1:0] srgb_entry(input int unsigned c);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] t4;
        logic [63:0] t8;
        logic [63:0] t12;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] q;
        if (c <= 10) begin
            q = (64'(c) * 64'd6553500 + 64'd164730) / 64'd329460;
            return q[CHAN_W-1:0];
        end
        t   = ((64'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
        t2  = (t * t) >> 30;
        t4  = (t2 * t2) >> 30;
        t8  = (t4 * t4) >> 30;
        t12 = (t8 * t4) >> 30;
        lo  = 64'd0;
        hi  = 64'd1 << 30;
        // largest y with y^5 <= t^12, i.e. t^2.4
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            if (pow5_q30(mid) <= t12) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        q = (lo * 64'd65535 + (64'd1 << 29)) >> 30;
        return q[CHAN_W-1:0];
    endfunction

    function automatic t_srgb_lut build_srgb_lut();
        t_srgb_lut lut;
        int        c;
        for (c = 0; c < 256; c++) begin
            lut[c] = srgb_entry(32'(c));
        end
        return lut;
    endfunction

    localparam t_srgb_lut SRGB_LUT = build_srgb_lut();

endpackage

@@ hw/rtl/bilinear_texture_sampler_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bilinear_texture_sampler_core
// rgba8 texture store with bilinear, repeat-wrapped sampling
// ---------------------------------------------------------------------------
// usage
//   request channel: start / busy with i_req. a request is taken at every
//   clock edge where start is high and busy is low; busy never rises, so a
//   request can enter in every cycle (one request per clock sustained).
//   write requests store one texel and give no result. sample requests give
//   one result on o_rsp, marked by o_done for exactly one cycle; o_done and
//   o_rsp are registered outputs, and results leave in request order.
//   the receiver cannot hold results off and the pipeline never stalls.
//   config channel: i_cfg_valid / o_cfg_ready (always ready) with an index
//   and data; write it only while no request is in flight. unknown indexes
//   are dropped.
//   11 register stages plus the output register; the four corner texels are
//   fetched from four copies of the texel store, one read port each, written
//   in parallel by write requests at the same stage as the reads, so request
//   order is kept for every read/write mix.
//   reset clears the pipeline valid bits and sets the config registers to
//   64 x 64, srgb decode on, texture present. the texel store is not
//   cleared; a texel reads as garbage until written.
// ---------------------------------------------------------------------------
module bilinear_texture_sampler_core #(
    parameter int unsigned MAX_DIM     = bts_pkg::MAX_DIM_DEF,
    parameter int unsigned TEXEL_DEPTH = bts_pkg::TEXEL_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  bts_pkg::t_req                    i_req,
    output logic                             o_done,
    output bts_pkg::t_rsp                    o_rsp,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bts_pkg::*;

    // widths that follow from the size limit and the store depth
    localparam int unsigned DW   = $clog2(MAX_DIM + 1);   // size value 1..MAX_DIM
    localparam int unsigned IW   = $clog2(MAX_DIM);       // texel index
    localparam int unsigned SXW  = FRAC_W + DW;           // scaled coordinate
    localparam int unsigned LW   = IW + DW;               // linear texel index
    localparam int unsigned AW   = $clog2(TEXEL_DEPTH);   // store address
    localparam int unsigned RW   = LW + 1;                // reciprocal width
    localparam int unsigned QPW  = LW + RW;               // reciprocal product
    localparam int unsigned QDW  = LW + AW + 1;           // quotient times depth
    localparam int unsigned OW   = FRAC_W + 1;            // one-minus-offset
    localparam int unsigned MW   = 2 * OW;                // weight product
    localparam int unsigned WTW  = 2 * FRAC_W + 1;        // weight, up to 2^32
    localparam int unsigned PW   = WTW + CHAN_W;          // weighted channel
    localparam int unsigned SW   = PW + 1;                // channel sum
    localparam int unsigned NTAP = 4;                     // corner texels
    localparam int unsigned NCH  = 4;                     // r, g, b, a

    // floor(2^LW / depth): estimate of index / depth, at most one too low
    localparam logic [RW-1:0]    RECIP     = RW'((64'd1 << LW) / 64'(TEXEL_DEPTH));
    localparam logic [AW:0]      DEPTH_V   = (AW + 1)'(TEXEL_DEPTH);
    localparam logic [DW-1:0]    MAX_DIM_V = DW'(MAX_DIM);
    localparam logic [OW-1:0]    ONE_Q16   = OW'(1) << FRAC_W;
    localparam logic [SW-1:0]    ROUND_V   = SW'(1) << (2 * FRAC_W - 1);

    typedef struct packed {
        t_cmd                cmd;
        logic [ADDR_W-1:0]   addr;
        logic [TEXEL_W-1:0]  data;
    } t_wr;

    typedef logic [NTAP-1:0][WTW-1:0] t_wts;

    // -----------------------------------------------------------------------
    // configuration registers
    // -----------------------------------------------------------------------
    logic [SIZE_W-1:0] r_tex_width;
    logic [SIZE_W-1:0] r_tex_height;
    logic              r_srgb_decode;
    logic              r_texture_present;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;   // fully pipelined, never holds off a request

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width       <= SIZE_W'(64);
            r_tex_height      <= SIZE_W'(64);
            r_srgb_decode     <= 1'b1;
            r_texture_present <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TEX_WIDTH:       r_tex_width       <= i_cfg_data;
                CFG_TEX_HEIGHT:      r_tex_height      <= i_cfg_data;
                CFG_SRGB_DECODE:     r_srgb_decode     <= i_cfg_data[0];
                CFG_TEXTURE_PRESENT: r_texture_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // sizes saturated to 1..MAX_DIM
    function automatic logic [DW-1:0] clamp_size(input logic [SIZE_W-1:0] r);
        if (r == '0) begin
            return DW'(1);
        end
        if (32'(r) > MAX_DIM) begin
            return MAX_DIM_V;
        end
        return DW'(r);
    endfunction

    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [DW-1:0] w_m1;
    logic [DW-1:0] h_m1;

    assign w_eff = clamp_size(r_tex_width);
    assign h_eff = clamp_size(r_tex_height);
    assign w_m1  = w_eff - DW'(1);
    assign h_m1  = h_eff - DW'(1);

    // -----------------------------------------------------------------------
    // pipeline registers
    // -----------------------------------------------------------------------
    logic [11:1]                r_vld;       // stage valid, samples only past 7
    t_wr                        r_wr [1:7];  // write payload rides to the store
    t_wts                       r_wt [4:9];  // corner weights ride to the mac

    logic [FRAC_W-1:0]          r_s1_fu;
    logic [FRAC_W-1:0]          r_s1_fv;
    logic [SXW-1:0]             r_s2_sx;
    logic [SXW-1:0]             r_s2_sy;
    logic [IW-1:0]              r_s3_ix;
    logic [IW-1:0]              r_s3_ix1;
    logic [IW-1:0]              r_s3_iy;
    logic [IW-1:0]              r_s3_iy1;
    logic [FRAC_W-1:0]          r_s3_ox;
    logic [FRAC_W-1:0]          r_s3_oy;
    logic [IW-1:0]              r_s4_ix;
    logic [IW-1:0]              r_s4_ix1;
    logic [LW-1:0]              r_s4_row0;
    logic [LW-1:0]              r_s4_row1;
    logic [NTAP-1:0][LW-1:0]    r_s5_lin;
    logic [NTAP-1:0][LW-1:0]    r_s6_lin;
    logic [NTAP-1:0][LW-1:0]    r_s6_q;
    logic [NTAP-1:0][AW:0]      r_s7_rem;
    logic [TEXEL_W-1:0]         r_s8_tex [NTAP];
    logic [NTAP-1:0][NCH-1:0][CHAN_W-1:0] r_s9_chan;
    logic [NCH-1:0][NTAP-1:0][PW-1:0]     r_s10_prod;
    logic [NCH-1:0][1:0][SW-1:0]          r_s11_pair;
    logic                       r_done;
    t_rsp                       r_rsp;

    // next values
    logic                       acc;
    logic [SXW-1:0]             n_sx;
    logic [SXW-1:0]             n_sy;
    logic [IW-1:0]              n_ix;
    logic [IW-1:0]              n_ix1;
    logic [IW-1:0]              n_iy;
    logic [IW-1:0]              n_iy1;
    logic [LW-1:0]              n_row0;
    logic [LW-1:0]              n_row1;
    t_wts                       n_wt;
    logic [NTAP-1:0][LW-1:0]    n_lin;
    logic [NTAP-1:0][LW-1:0]    n_q;
    logic [NTAP-1:0][AW:0]      n_rem;
    logic [NTAP-1:0][AW-1:0]    rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [NTAP-1:0][NCH-1:0][CHAN_W-1:0] n_chan;
    logic [NCH-1:0][NTAP-1:0][PW-1:0]     n_prod;
    logic [NCH-1:0][1:0][SW-1:0]          n_pair;
    t_rsp                       n_rsp;

    assign acc = start && !busy;

    // stage 1 -> 2: scale the fractional coordinate by the texture size
    assign n_sx = SXW'(r_s1_fu) * SXW'(w_eff);
    assign n_sy = SXW'(r_s1_fv) * SXW'(h_eff);

    // stage 2 -> 3: integer texel, clamp, wrapped neighbor, offsets
    always_comb begin
        logic [DW-1:0] ixr;
        logic [DW-1:0] iyr;
        logic [DW-1:0] ixc;
        logic [DW-1:0] iyc;
        ixr   = r_s2_sx[SXW-1:FRAC_W];
        iyr   = r_s2_sy[SXW-1:FRAC_W];
        ixc   = (ixr > w_m1) ? w_m1 : ixr;
        iyc   = (iyr > h_m1) ? h_m1 : iyr;
        n_ix  = IW'(ixc);
        n_iy  = IW'(iyc);
        n_ix1 = (ixc == w_m1) ? '0 : IW'(ixc + DW'(1));
        n_iy1 = (iyc == h_m1) ? '0 : IW'(iyc + DW'(1));
    end

    // stage 3 -> 4: row bases and bilinear weights
    always_comb begin
        logic [OW-1:0] nx;
        logic [OW-1:0] ny;
        logic [OW-1:0] ex;
        logic [OW-1:0] ey;
        logic [MW-1:0] m0;
        logic [MW-1:0] m1;
        logic [MW-1:0] m2;
        logic [MW-1:0] m3;
        ex      = OW'(r_s3_ox);
        ey      = OW'(r_s3_oy);
        nx      = ONE_Q16 - ex;
        ny      = ONE_Q16 - ey;
        m0      = MW'(nx) * MW'(ny);
        m1      = MW'(nx) * MW'(ey);
        m2      = MW'(ex) * MW'(ny);
        m3      = MW'(ex) * MW'(ey);
        n_wt[0] = m0[WTW-1:0];
        n_wt[1] = m1[WTW-1:0];
        n_wt[2] = m2[WTW-1:0];
        n_wt[3] = m3[WTW-1:0];
        n_row0  = LW'(r_s3_iy) * LW'(w_eff);
        n_row1  = LW'(r_s3_iy1) * LW'(w_eff);
    end

    // stage 4 -> 5: linear indexes of the corners
    // corner order: (x, y), (x, y+1), (x+1, y), (x+1, y+1)
    assign n_lin[0] = r_s4_row0 + LW'(r_s4_ix);
    assign n_lin[1] = r_s4_row1 + LW'(r_s4_ix);
    assign n_lin[2] = r_s4_row0 + LW'(r_s4_ix1);
    assign n_lin[3] = r_s4_row1 + LW'(r_s4_ix1);

    // stages 5 -> 7: index mod depth by reciprocal, one correction step
    always_comb begin
        logic [QPW-1:0] qp;
        logic [QDW-1:0] qd;
        logic [QDW-1:0] rr;
        for (int k = 0; k < NTAP; k++) begin
            qp       = QPW'(r_s5_lin[k]) * QPW'(RECIP);
            n_q[k]   = LW'(qp >> LW);
            qd       = QDW'(r_s6_q[k]) * QDW'(DEPTH_V);
            rr       = QDW'(r_s6_lin[k]) - qd;
            n_rem[k] = rr[AW:0];
        end
    end

    always_comb begin
        logic [AW:0] sub;
        for (int k = 0; k < NTAP; k++) begin
            sub        = r_s7_rem[k] - DEPTH_V;
            rd_addr[k] = (r_s7_rem[k] >= DEPTH_V) ? sub[AW-1:0] : r_s7_rem[k][AW-1:0];
        end
    end

    // writes land at the read stage so each request sees the store in order
    assign wr_en   = r_vld[7] && (r_wr[7].cmd == CMD_WRITE)
                     && (32'(r_wr[7].addr) < TEXEL_DEPTH);
    assign wr_addr = AW'(32'(r_wr[7].addr));

    // four copies of the texel store, one read port each
    for (genvar g = 0; g < NTAP; g++) begin : g_bank
        logic [TEXEL_W-1:0] mem [TEXEL_DEPTH];

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                mem[wr_addr] <= r_wr[7].data;
            end
            r_s8_tex[g] <= mem[rd_addr[g]];
        end
    end

    // stage 8 -> 9: channel decode; color through srgb table or byte*257
    always_comb begin
        logic [7:0] b;
        for (int k = 0; k < NTAP; k++) begin
            for (int ch = 0; ch < NCH; ch++) begin
                b = r_s8_tex[k][8*ch +: 8];
                if ((ch < NCH - 1) && r_srgb_decode) begin
                    n_chan[k][ch] = SRGB_LUT[b];
                end else begin
                    n_chan[k][ch] = {b, b};
                end
            end
        end
    end

    // stage 9 -> 10: weight times channel
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            for (int k = 0; k < NTAP; k++) begin
                n_prod[ch][k] = PW'(r_wt[9][k]) * PW'(r_s9_chan[k][ch]);
            end
        end
    end

    // stage 10 -> 11: first level of the sum tree
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            n_pair[ch][0] = SW'(r_s10_prod[ch][0]) + SW'(r_s10_prod[ch][1]);
            n_pair[ch][1] = SW'(r_s10_prod[ch][2]) + SW'(r_s10_prod[ch][3]);
        end
    end

    // stage 11 -> out: final add, round, saturate; all ones without a texture
    always_comb begin
        logic [SW-1:0]          tot;
        logic [SW-2*FRAC_W-1:0] hi;
        logic [NCH-1:0][CHAN_W-1:0] v;
        for (int ch = 0; ch < NCH; ch++) begin
            tot = r_s11_pair[ch][0] + r_s11_pair[ch][1] + ROUND_V;
            hi  = tot[SW-1:2*FRAC_W];
            v[ch] = (hi > (SW-2*FRAC_W)'({CHAN_W{1'b1}})) ? {CHAN_W{1'b1}} : CHAN_W'(hi);
        end
        if (!r_texture_present) begin
            n_rsp = '1;
        end else begin
            n_rsp.red   = v[0];
            n_rsp.green = v[1];
            n_rsp.blue  = v[2];
            n_rsp.alpha = v[3];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld[1]    <= acc;
            r_vld[7:2]  <= r_vld[6:1];
            r_vld[8]    <= r_vld[7] && (r_wr[7].cmd == CMD_SAMPLE);
            r_vld[11:9] <= r_vld[10:8];
            r_done      <= r_vld[11];
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_wr[1].cmd  <= i_req.command;
        r_wr[1].addr <= i_req.texel_address;
        r_wr[1].data <= i_req.texel_data;
        for (int s = 2; s <= 7; s++) begin
            r_wr[s] <= r_wr[s-1];
        end
        r_s1_fu    <= i_req.coord_u[FRAC_W-1:0];
        r_s1_fv    <= i_req.coord_v[FRAC_W-1:0];
        r_s2_sx    <= n_sx;
        r_s2_sy    <= n_sy;
        r_s3_ix    <= n_ix;
        r_s3_ix1   <= n_ix1;
        r_s3_iy    <= n_iy;
        r_s3_iy1   <= n_iy1;
        r_s3_ox    <= r_s2_sx[FRAC_W-1:0];
        r_s3_oy    <= r_s2_sy[FRAC_W-1:0];
        r_s4_ix    <= r_s3_ix;
        r_s4_ix1   <= r_s3_ix1;
        r_s4_row0  <= n_row0;
        r_s4_row1  <= n_row1;
        r_wt[4]    <= n_wt;
        for (int s = 5; s <= 9; s++) begin
            r_wt[s] <= r_wt[s-1];
        end
        r_s5_lin   <= n_lin;
        r_s6_lin   <= r_s5_lin;
        r_s6_q     <= n_q;
        r_s7_rem   <= n_rem;
        r_s9_chan  <= n_chan;
        r_s10_prod <= n_prod;
        r_s11_pair <= n_pair;
        r_rsp      <= n_rsp;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // -----------------------------------------------------------------------
    // assertions
    // -----------------------------------------------------------------------
    a_done_from_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy && (i_req.command == CMD_SAMPLE), 12))
        else $error("result without a sample request 12 cycles earlier");

    a_sample_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req.command == CMD_SAMPLE)) |-> ##12 o_done)
        else $error("sample request lost in the pipeline");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[7] |-> ((32'(rd_addr[0]) < TEXEL_DEPTH) && (32'(rd_addr[3]) < TEXEL_DEPTH)))
        else $error("reduced texel address beyond the store");

    a_weights_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && (r_wr[4].cmd == CMD_SAMPLE)) |->
        ((WTW + 2)'(r_wt[4][0]) + (WTW + 2)'(r_wt[4][1]) + (WTW + 2)'(r_wt[4][2])
         + (WTW + 2)'(r_wt[4][3]) == ((WTW + 2)'(1) << (2 * FRAC_W))))
        else $error("bilinear weights do not sum to one");

endmodule

@@ bench/bts_sample_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bts_sample_checker
// watches the request, result and register channels of the texture sampler,
// keeps its own texel mirror and register copy, and compares every filtered
// color against an independently computed one, oldest first
// ---------------------------------------------------------------------------
module bts_sample_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  bts_pkg::t_req                  i_req,
    input  logic                           i_done,
    input  bts_pkg::t_rsp                  i_rsp,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [bts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bts_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int unsigned                    o_fail_count,
    output int unsigned                    o_pending,
    output int unsigned                    o_checked
);
    import bts_pkg::*;

    localparam int unsigned DEPTH = TEXEL_DEPTH_DEF;

    logic [TEXEL_W-1:0] texel_mirror [DEPTH];
    logic [CHAN_W-1:0]  srgb_linear [256];
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic               srgb_reg;
    logic               present_reg;
    t_rsp               color_due [$];
    t_rsp               oldest;
    int unsigned        fails   = 0;
    int unsigned        checked = 0;

    // srgb code to 16-bit linear: c^... via t^12 and a fifth-root search in q30
    function automatic logic [CHAN_W-1:0] decode_srgb_code(input int unsigned code);
        logic [63:0] base;
        logic [63:0] sq;
        logic [63:0] p4;
        logic [63:0] p8;
        logic [63:0] p12;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] pw;
        logic [63:0] q;
        int          k;
        if (code <= 10) begin
            q = (64'(code) * 64'd6553500 + 64'd164730) / 64'd329460;
            return q[CHAN_W-1:0];
        end
        base = ((64'(code) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
        sq   = (base * base) >> 30;
        p4   = (sq * sq) >> 30;
        p8   = (p4 * p4) >> 30;
        p12  = (p8 * p4) >> 30;
        lo   = 64'd0;
        hi   = 64'd1 << 30;
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            pw  = mid;
            for (k = 0; k < 4; k++) begin
                pw = (pw * mid) >> 30;
            end
            if (pw <= p12) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        q = (lo * 64'd65535 + (64'd1 << 29)) >> 30;
        return q[CHAN_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return SIZE_W'(1);
        end
        if (v > SIZE_W'(MAX_DIM_DEF)) begin
            return SIZE_W'(MAX_DIM_DEF);
        end
        return v;
    endfunction

    function automatic logic [CHAN_W-1:0] chan_linear(input logic [TEXEL_W-1:0] texel,
                                                      input int ch);
        logic [7:0] b;
        b = texel[8*ch +: 8];
        if (ch < 3 && srgb_reg) begin
            return srgb_linear[b];
        end
        return {b, b};
    endfunction

    // four-corner blend with repeat wrap, weights sum to 2^32
    function automatic t_rsp bilinear_color(input t_req r);
        t_rsp               res;
        logic [SIZE_W-1:0]  w;
        logic [SIZE_W-1:0]  h;
        logic [31:0]        sx;
        logic [31:0]        sy;
        logic [31:0]        ix;
        logic [31:0]        iy;
        logic [31:0]        ix1;
        logic [31:0]        iy1;
        logic [16:0]        ox;
        logic [16:0]        oy;
        logic [TEXEL_W-1:0] corner [4];
        logic [63:0]        wt [4];
        logic [63:0]        acc;
        logic [63:0]        rnd;
        logic [CHAN_W-1:0]  val [4];
        int                 ch;
        int                 k;
        if (!present_reg) begin
            res = {4{16'hFFFF}};
            return res;
        end
        w  = clamp_dim(width_reg);
        h  = clamp_dim(height_reg);
        sx = 32'(r.coord_u[15:0]) * 32'(w);
        sy = 32'(r.coord_v[15:0]) * 32'(h);
        ix = sx >> 16;
        iy = sy >> 16;
        if (ix > 32'(w) - 1) ix = 32'(w) - 1;
        if (iy > 32'(h) - 1) iy = 32'(h) - 1;
        ox  = {1'b0, sx[15:0]};
        oy  = {1'b0, sy[15:0]};
        ix1 = (ix + 1) % 32'(w);
        iy1 = (iy + 1) % 32'(h);
        corner[0] = texel_mirror[(iy  * 32'(w) + ix ) % DEPTH];
        corner[1] = texel_mirror[(iy1 * 32'(w) + ix ) % DEPTH];
        corner[2] = texel_mirror[(iy  * 32'(w) + ix1) % DEPTH];
        corner[3] = texel_mirror[(iy1 * 32'(w) + ix1) % DEPTH];
        wt[0] = 64'(17'h10000 - ox) * 64'(17'h10000 - oy);
        wt[1] = 64'(17'h10000 - ox) * 64'(oy);
        wt[2] = 64'(ox) * 64'(17'h10000 - oy);
        wt[3] = 64'(ox) * 64'(oy);
        for (ch = 0; ch < 4; ch++) begin
            acc = 64'd0;
            for (k = 0; k < 4; k++) begin
                acc += wt[k] * 64'(chan_linear(corner[k], ch));
            end
            rnd = (acc + 64'h8000_0000) >> 32;
            if (rnd > 64'hFFFF) rnd = 64'hFFFF;
            val[ch] = rnd[CHAN_W-1:0];
        end
        res.red   = val[0];
        res.green = val[1];
        res.blue  = val[2];
        res.alpha = val[3];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                               input logic [CHAN_W-1:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    initial begin
        for (int c = 0; c < 256; c++) begin
            srgb_linear[c] = decode_srgb_code(c);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg   = SIZE_W'(64);
            height_reg  = SIZE_W'(64);
            srgb_reg    = 1'b1;
            present_reg = 1'b1;
            color_due.delete();
        end else begin
            if (i_done) begin
                if (color_due.size() == 0) begin
                    fails++;
                    $display("%0t: result with nothing expected, actual %h", $time, i_rsp);
                end else begin
                    oldest = color_due.pop_front();
                    checked++;
                    check_field("red",   oldest.red,   i_rsp.red);
                    check_field("green", oldest.green, i_rsp.green);
                    check_field("blue",  oldest.blue,  i_rsp.blue);
                    check_field("alpha", oldest.alpha, i_rsp.alpha);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TEX_WIDTH:       width_reg   = i_cfg_data[SIZE_W-1:0];
                    CFG_TEX_HEIGHT:      height_reg  = i_cfg_data[SIZE_W-1:0];
                    CFG_SRGB_DECODE:     srgb_reg    = i_cfg_data[0];
                    CFG_TEXTURE_PRESENT: present_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (i_req.command == CMD_SAMPLE) begin
                    color_due = {color_due, bilinear_color(i_req)};
                end else if (32'(i_req.texel_address) < DEPTH) begin
                    texel_mirror[i_req.texel_address] = i_req.texel_data;
                end
            end
        end
        o_pending    <= color_due.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// drives texel writes, sample requests and register settings into the
// bilinear texture sampler; the checker beside it predicts and compares
// ---------------------------------------------------------------------------
module tb_top;
    import bts_pkg::*;

    // result latency after the accepting edge, plus some margin
    localparam int unsigned RSP_LATENCY     = 12;
    localparam int unsigned SETTLE_CYCLES   = RSP_LATENCY + 4;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned NUM_PHASES      = 10;
    localparam int unsigned ITEMS_PER_PHASE = 32;
    // texels written up front; every sampled size keeps width times height inside
    localparam int unsigned PRELOAD_TEXELS  = 256;
    // register index the block does not decode, must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    t_req                  req;
    logic                  done;
    t_rsp                  rsp;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned cycle_count = 0;
    int unsigned n_samples   = 0;
    int unsigned n_writes    = 0;
    int unsigned n_settings  = 0;
    bit          burst       = 1'b0;

    always #1 clk = ~clk;

    bilinear_texture_sampler_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req),
        .o_done      (done),
        .o_rsp       (rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    bts_sample_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (req),
        .i_done       (done),
        .i_rsp        (rsp),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // watchdog: a hung pipeline or a lost result ends the run here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached, %0d results still due", $time, pending);
            $display("** bilinear_texture_sampler_core: FAILED **");
            $finish;
        end
    end

    // mostly back to back, sometimes a short gap, rarely a long hole; none in a burst
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // coordinates: fully random, edge fractions, or small magnitudes of either sign
    function automatic logic signed [COORD_W-1:0] pick_coord();
        logic [15:0]               frac;
        logic signed [COORD_W-1:0] c;
        case ($urandom_range(0, 3))
            0, 1: c = COORD_W'($urandom());
            2: begin
                case ($urandom_range(0, 4))
                    0: frac = 16'h0000;
                    1: frac = 16'h0001;
                    2: frac = 16'hFFFF;
                    3: frac = 16'hFFFE;
                    default: frac = 16'h8000;
                endcase
                c = {8'($urandom()), frac};
            end
            default: begin
                c = COORD_W'($urandom_range(0, 131071));
                if ($urandom_range(0, 1)) c = -c;
            end
        endcase
        return c;
    endfunction

    function automatic t_req mk_write(input logic [ADDR_W-1:0] addr,
                                      input logic [TEXEL_W-1:0] data);
        t_req r;
        r.command       = CMD_WRITE;
        r.texel_address = addr;
        r.texel_data    = data;
        r.coord_u       = COORD_W'($urandom());
        r.coord_v       = COORD_W'($urandom());
        return r;
    endfunction

    function automatic t_req mk_sample(input logic signed [COORD_W-1:0] u,
                                       input logic signed [COORD_W-1:0] v);
        t_req r;
        r.command       = CMD_SAMPLE;
        r.texel_address = ADDR_W'($urandom());
        r.texel_data    = $urandom();
        r.coord_u       = u;
        r.coord_v       = v;
        return r;
    endfunction

    // one request through the start/busy handshake, then a random gap;
    // start is only lowered when a gap follows, never in the same step it rises
    task automatic send(input t_req r);
        int unsigned gap;
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (r.command == CMD_SAMPLE) n_samples++;
        else n_writes++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // sender holds off until every due result is back and the pipe is empty
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // registers change only with the pipe idle; an unused index rides along
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] w,
                                  input logic [CFG_DATA_W-1:0] h,
                                  input logic [CFG_DATA_W-1:0] srgb,
                                  input logic [CFG_DATA_W-1:0] present);
        drain();
        write_reg(CFG_TEX_WIDTH, w);
        write_reg(CFG_TEX_HEIGHT, h);
        write_reg(CFG_SRGB_DECODE, srgb);
        write_reg(CFG_TEXTURE_PRESENT, present);
        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom()));
        cfg_valid <= 1'b0;
        @(posedge clk);
        n_settings++;
    endtask

    // size register value: mostly in range, some saturating, some at the ends
    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            case ($urandom_range(0, 3))
                0: return 7'd0;
                1: return 7'd1;
                2: return 7'd64;
                default: return 7'd127;
            endcase
        end
        if (r == 1) return CFG_DATA_W'($urandom_range(65, 127));
        if (r < 6) return CFG_DATA_W'($urandom_range(1, 8));
        return CFG_DATA_W'($urandom_range(1, 64));
    endfunction

    // size the block actually uses for a register value
    function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] d);
        if (d == '0) return 1;
        if (32'(d) > MAX_DIM_DEF) return MAX_DIM_DEF;
        return 32'(d);
    endfunction

    initial begin
        int unsigned           a;
        int unsigned           p;
        int unsigned           n;
        logic [CFG_DATA_W-1:0] w_pick;
        logic [CFG_DATA_W-1:0] h_pick;
        // every input known from time zero, reset held low before the first request
        rst_n     <= 1'b0;
        start     <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // preload the texels that any sampled size can reach
        burst = 1'b1;
        for (a = 0; a < PRELOAD_TEXELS; a++) begin
            send(mk_write(ADDR_W'(a), $urandom()));
        end
        burst = 1'b0;

        // directed: texel extremes, small srgb codes, first and last address
        send(mk_write(12'd0, 32'h0000_0000));
        send(mk_write(12'd1, 32'hFFFF_FFFF));
        send(mk_write(12'd64, 32'h0A0B_0A0B));
        send(mk_write(12'd4095, 32'h8040_C0FF));
        // full width, four rows
        apply_settings(7'd64, 7'd4, 7'd1, 7'd1);
        // exact texel, half-way blend, coordinate extremes, wrap at both edges
        send(mk_sample(24'sh000000, 24'sh000000));
        send(mk_sample(24'sh000200, 24'sh000000));
        send(mk_sample(24'sh7FFFFF, -24'sh800000));
        send(mk_sample(-24'sh000001, -24'sh000001));
        send(mk_sample(24'sh000000, 24'sh000400));
        send(mk_sample(24'sh000200, 24'sh000200));
        // srgb decode off: linear byte path for all channels
        apply_settings(7'd64, 7'd4, 7'd0, 7'd1);
        send(mk_sample(24'sh000200, 24'sh000000));
        send(mk_sample(24'sh000000, 24'sh000400));
        // missing texture: all ones whatever the coordinates
        apply_settings(7'd64, 7'd64, 7'd1, 7'd0);
        send(mk_sample(pick_coord(), pick_coord()));
        // zero sizes saturate up to one texel
        apply_settings(7'd0, 7'd0, 7'd1, 7'd1);
        send(mk_sample(pick_coord(), pick_coord()));
        // oversize width saturates down to the maximum
        apply_settings(7'd127, 7'd4, 7'd0, 7'd1);
        send(mk_sample(-24'sh000001, -24'sh000001));
        send(mk_sample(24'sh00FFFF, 24'sh000000));
        // oversize height saturates down to the maximum
        apply_settings(7'd4, 7'd100, 7'd1, 7'd1);
        send(mk_sample(-24'sh000001, -24'sh000001));
        send(mk_sample(24'sh000000, 24'sh00FFFF));
        // one-texel-wide and one-texel-high strips
        apply_settings(7'd1, 7'd64, 7'd1, 7'd1);
        send(mk_sample(pick_coord(), pick_coord()));
        apply_settings(7'd64, 7'd1, 7'd1, 7'd1);
        send(mk_sample(pick_coord(), pick_coord()));

        // random phases, each under its own register setting
        for (p = 0; p < NUM_PHASES; p++) begin
            w_pick = pick_dim();
            h_pick = pick_dim();
            // keep the sampled area inside the preloaded texels
            if (eff_dim(w_pick) * eff_dim(h_pick) > PRELOAD_TEXELS) begin
                h_pick = CFG_DATA_W'(PRELOAD_TEXELS / eff_dim(w_pick));
            end
            apply_settings(w_pick, h_pick, CFG_DATA_W'($urandom()),
                           ($urandom_range(0, 7) != 0) ? 7'd1 : 7'd0);
            burst = ($urandom_range(0, 3) == 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    send(mk_write(ADDR_W'($urandom()), $urandom()));
                end else begin
                    send(mk_sample(pick_coord(), pick_coord()));
                end
                // now and then stop mid-phase until the pipe has emptied
                if (n == ITEMS_PER_PHASE / 2 && $urandom_range(0, 1)) drain();
            end
            burst = 1'b0;
        end

        drain();
        $display("run covered %0d sample requests and %0d texel writes over %0d settings",
                 n_samples, n_writes, n_settings);
        $display("%0d filtered colors compared, %0d failures", checked, fail_count);
        if (pending != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("** bilinear_texture_sampler_core: PASSED **");
        end else begin
            $display("** bilinear_texture_sampler_core: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bts_pkg.sv
hw/rtl/bilinear_texture_sampler_core.sv
bench/bts_sample_checker.sv
bench/tb_top.sv
